FILE: hw/rtl/lpfr_pkg.sv
package lpfr_pkg;

  // register map (byte address = 4 * index)
  localparam int unsigned RegCount = 4;
  localparam int unsigned AddrWidth = 4;

  localparam logic [1:0] REG_START_BYTE   = 2'd0;
  localparam logic [1:0] REG_MSG_TYPE     = 2'd1;
  localparam logic [1:0] REG_WAIT_TYPE    = 2'd2;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd3;

  // register reset values
  localparam logic [7:0]  START_BYTE_RST   = 8'd62;
  localparam logic [7:0]  MSG_TYPE_RST     = 8'd8;
  localparam logic [7:0]  WAIT_TYPE_RST    = 8'd131;
  localparam logic [15:0] LENGTH_LIMIT_RST = 16'd511;

  // first payload offset that carries message text
  localparam logic [15:0] MSG_OFFSET = 16'd6;

  typedef enum logic [2:0] {
    KIND_MSG_BYTE  = 3'd0,
    KIND_EMPTY_MSG = 3'd1,
    KIND_FETCH     = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_OVERSIZE  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  msg_type;
    logic [7:0]  wait_type;
    logic [15:0] length_limit;
  } cfg_t;

  typedef struct packed {
    logic       vld;
    kind_e      kind;
    logic [7:0] channel;
    logic [7:0] data_byte;
    logic       last;
  } res_t;

endpackage

FILE: hw/rtl/lpfr_regs.sv
module lpfr_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpfr_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output lpfr_pkg::cfg_t                 cfg_o
);
  import lpfr_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes, value masked to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= START_BYTE_RST;
      cfg_q.msg_type     <= MSG_TYPE_RST;
      cfg_q.wait_type    <= WAIT_TYPE_RST;
      cfg_q.length_limit <= LENGTH_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_BYTE:   cfg_q.start_byte   <= pwdata[7:0];
        REG_MSG_TYPE:     cfg_q.msg_type     <= pwdata[7:0];
        REG_WAIT_TYPE:    cfg_q.wait_type    <= pwdata[7:0];
        REG_LENGTH_LIMIT: cfg_q.length_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_START_BYTE:   prdata = {24'd0, cfg_q.start_byte};
      REG_MSG_TYPE:     prdata = {24'd0, cfg_q.msg_type};
      REG_WAIT_TYPE:    prdata = {24'd0, cfg_q.wait_type};
      REG_LENGTH_LIMIT: prdata = {16'd0, cfg_q.length_limit};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/lpfr_core.sv
module lpfr_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lpfr_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  output lpfr_pkg::res_t res_o
);
  import lpfr_pkg::*;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_DATA   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  chan_q, chan_d;

  logic [15:0] len_full;
  logic [7:0]  cur_type;
  logic [7:0]  cur_chan;
  logic        at_end;
  logic        is_msg;
  res_t        res;

  // header fields as they stand after this byte
  assign len_full = {byte_i, len_q[7:0]};
  assign cur_type = (pos_q == 16'd0) ? byte_i : type_q;
  assign cur_chan = (pos_q == 16'd1) ? byte_i : chan_q;
  assign at_end   = ({1'b0, pos_q} + 17'd1) >= {1'b0, len_q};
  assign is_msg   = (cur_type == cfg_i.msg_type) && (len_q >= MSG_OFFSET);

  // phase logic for one received byte
  always_comb begin
    phase_d       = phase_q;
    len_d         = len_q;
    pos_d         = pos_q;
    type_d        = type_q;
    chan_d        = chan_q;
    res.vld       = 1'b0;
    res.kind      = KIND_MSG_BYTE;
    res.channel   = 8'd0;
    res.data_byte = 8'd0;
    res.last      = 1'b0;
    case (phase_q)
      PH_START: begin
        if (byte_i == cfg_i.start_byte) begin
          phase_d = PH_LEN_LO;
          pos_d   = 16'd0;
          type_d  = 8'd0;
          chan_d  = 8'd0;
        end
      end
      PH_LEN_LO: begin
        len_d   = {8'd0, byte_i};
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d = len_full;
        if (len_full > cfg_i.length_limit) begin
          phase_d  = PH_START;
          res.vld  = 1'b1;
          res.kind = KIND_OVERSIZE;
        end else if (len_full == 16'd0) begin
          phase_d = PH_START;
        end else begin
          phase_d = PH_DATA;
          pos_d   = 16'd0;
        end
      end
      PH_DATA: begin
        type_d = cur_type;
        chan_d = cur_chan;
        if (is_msg && (pos_q >= MSG_OFFSET)) begin
          res.vld       = 1'b1;
          res.kind      = KIND_MSG_BYTE;
          res.channel   = cur_chan;
          res.data_byte = byte_i;
          res.last      = at_end;
        end else if (at_end) begin
          res.vld = 1'b1;
          if (is_msg) begin
            res.kind    = KIND_EMPTY_MSG;
            res.channel = cur_chan;
            res.last    = 1'b1;
          end else if (cur_type == cfg_i.wait_type) begin
            res.kind = KIND_FETCH;
          end else begin
            res.kind = KIND_UNKNOWN;
          end
        end
        if (at_end) begin
          phase_d = PH_START;
          pos_d   = 16'd0;
        end else begin
          pos_d = pos_q + 16'd1;
        end
      end
      default: phase_d = PH_START;
    endcase
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      len_q   <= 16'd0;
      pos_q   <= 16'd0;
      type_q  <= 8'd0;
      chan_q  <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      chan_q  <= chan_d;
    end
  end

  assign res_o = res;

endmodule

FILE: hw/rtl/length_prefixed_frame_receiver.sv
// Length-prefixed frame receiver: takes one received byte per request on the rx channel and
// gives at most one result per byte on the out channel. A byte is registered, then run through
// the combinational frame phase logic into the result register. While the out channel takes
// results, a new byte can be taken every cycle; back-pressure on the out channel stalls the
// input register and then rx_ready_o. Registers (APB, byte address 4*index): 0 start_byte
// (reset 62), 1 channel_message_type (8), 2 waiting_type (131), 3 length_limit (511).
// Result kinds: 0 message byte, 1 empty message, 2 fetch request, 3 unknown frame,
// 4 oversize frame dropped. Write registers only while the block is idle.
module length_prefixed_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpfr_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // received bytes
  input  logic                           rx_valid_i,
  output logic                           rx_ready_o,
  input  logic [7:0]                     rx_byte_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     kind_o,
  output logic [7:0]                     channel_o,
  output logic [7:0]                     data_byte_o,
  output logic                           last_of_message_o
);
  import lpfr_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       proc_fire;
  logic       out_vld_q;
  kind_e      out_kind_q;
  logic [7:0] out_chan_q;
  logic [7:0] out_data_q;
  logic       out_last_q;

  lpfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input byte moves on when the result register is free or being drained
  assign proc_fire  = in_vld_q && (!out_vld_q || out_ready_i);
  assign rx_ready_o = !in_vld_q || proc_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_vld_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  lpfr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (proc_fire),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_fire) begin
      out_vld_q <= res.vld;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res.vld) begin
      out_kind_q <= res.kind;
      out_chan_q <= res.channel;
      out_data_q <= res.data_byte;
      out_last_q <= res.last;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign kind_o            = out_kind_q;
  assign channel_o         = out_chan_q;
  assign data_byte_o       = out_data_q;
  assign last_of_message_o = out_last_q;

  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> (in_vld_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // last mark only on message results
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_message_o) |->
      (kind_o == KIND_MSG_BYTE || kind_o == KIND_EMPTY_MSG))
    else $error("last mark on a non-message result");

  // empty message always carries the last mark and no data
  a_empty_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_EMPTY_MSG) |->
      (last_of_message_o && data_byte_o == 8'd0))
    else $error("malformed empty message result");

  // non-message results carry no channel
  a_no_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_FETCH || kind_o == KIND_UNKNOWN ||
                     kind_o == KIND_OVERSIZE)) |-> (channel_o == 8'd0))
    else $error("channel set on a non-message result");

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfr_pkg::*;

  // receiver phases as the frame parser walks through them
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD
  } rx_phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] channel;
    logic [7:0] data_byte;
    logic       last;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = '0;
  logic       rx_taken = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] channel;
  logic [7:0] data_byte;
  logic       last_of_message;

  // bytes waiting to be sent and results still owed by the receiver
  logic [7:0]    rx_pending[$];
  frame_result_t result_q[$];

  // mirror of the register file and of the parser state
  cfg_t        cfg;
  rx_phase_e   rx_phase = PH_HUNT;
  logic [15:0] fr_len = '0;
  logic [15:0] fr_pos = '0;
  logic [7:0]  fr_type = '0;
  logic [7:0]  fr_chan = '0;

  int unsigned idle_pct = 32;
  int unsigned err_cnt = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned settings_run = 1;

  length_prefixed_frame_receiver u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .rx_valid_i       (rx_valid),
    .rx_ready_o       (rx_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .kind_o           (kind),
    .channel_o        (channel),
    .data_byte_o      (data_byte),
    .last_of_message_o(last_of_message)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void queue_result(input kind_e k, input logic [7:0] ch,
                                       input logic [7:0] d, input logic l);
    frame_result_t r;
    r.kind = k;
    r.channel = ch;
    r.data_byte = d;
    r.last = l;
    result_q.push_back(r);
  endfunction

  // advance the parser mirror by one received byte
  function automatic void predict_frame_byte(input logic [7:0] b);
    logic [15:0] pos;
    logic        at_end;
    logic        is_msg;
    case (rx_phase)
      PH_HUNT: begin
        if (b == cfg.start_byte) begin
          rx_phase = PH_LEN_LO;
          fr_pos = '0;
          fr_type = '0;
          fr_chan = '0;
        end
      end
      PH_LEN_LO: begin
        fr_len = {8'h00, b};
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        fr_len[15:8] = b;
        if (fr_len > cfg.length_limit) begin
          rx_phase = PH_HUNT;
          queue_result(KIND_OVERSIZE, 8'h00, 8'h00, 1'b0);
        end else if (fr_len == 16'd0) begin
          rx_phase = PH_HUNT;
        end else begin
          rx_phase = PH_PAYLOAD;
          fr_pos = '0;
        end
      end
      default: begin
        pos = fr_pos;
        if (pos == 16'd0) fr_type = b;
        if (pos == 16'd1) fr_chan = b;
        at_end = ({1'b0, pos} + 17'd1) >= {1'b0, fr_len};
        is_msg = (fr_type == cfg.msg_type) && (fr_len >= MSG_OFFSET);
        if (is_msg && pos >= MSG_OFFSET) begin
          queue_result(KIND_MSG_BYTE, fr_chan, b, at_end);
        end else if (at_end) begin
          if (is_msg) queue_result(KIND_EMPTY_MSG, fr_chan, 8'h00, 1'b1);
          else if (fr_type == cfg.wait_type) queue_result(KIND_FETCH, 8'h00, 8'h00, 1'b0);
          else queue_result(KIND_UNKNOWN, 8'h00, 8'h00, 1'b0);
        end
        if (at_end) begin
          rx_phase = PH_HUNT;
          fr_pos = '0;
        end else begin
          fr_pos = pos + 16'd1;
        end
      end
    endcase
  endfunction

  // drive bytes and output back-pressure at the falling edge
  always @(negedge clk_i) begin : rx_driver
    logic hold;
    if (!rst_ni) begin
      rx_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      hold = rx_valid && !rx_taken;
      if (!hold && rx_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        rx_byte <= rx_pending.pop_front();
        hold = 1'b1;
      end
      rx_valid <= hold;
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk_i) begin : result_monitor
    frame_result_t want;
    if (!rst_ni) begin
      rx_taken <= 1'b0;
    end else begin
      rx_taken <= rx_valid && rx_ready;
      if (rx_valid && rx_ready) begin
        predict_frame_byte(rx_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result kind %0d channel %0d data_byte %0d last %0d",
                 kind, channel, data_byte, last_of_message);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          results_seen++;
          if (kind !== want.kind) begin
            $error("kind expected %0d actual %0d", want.kind, kind);
            err_cnt++;
          end
          if (channel !== want.channel) begin
            $error("channel expected %0d actual %0d", want.channel, channel);
            err_cnt++;
          end
          if (data_byte !== want.data_byte) begin
            $error("data_byte expected %0d actual %0d", want.data_byte, data_byte);
            err_cnt++;
          end
          if (last_of_message !== want.last) begin
            $error("last_of_message expected %0d actual %0d", want.last, last_of_message);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic send(input logic [7:0] b);
    rx_pending.push_back(b);
  endtask

  // start byte, little-endian length, then body bytes with the type first
  task automatic push_frame(input logic [15:0] len, input int unsigned body,
                            input logic [7:0] ftype);
    send(cfg.start_byte);
    send(len[7:0]);
    send(len[15:8]);
    for (int unsigned i = 0; i < body; i++) send(i == 0 ? ftype : 8'($urandom));
  endtask

  // mostly well-formed frames, plus noise, cut-off frames and oversize ones
  task automatic gen_frames(input int unsigned n_bytes);
    int unsigned stop;
    int unsigned sel;
    int unsigned len;
    int unsigned top;
    logic [7:0]  ftype;
    stop = rx_pending.size() + n_bytes;
    while (rx_pending.size() < stop) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        repeat ($urandom_range(3, 1)) send(8'($urandom));
      end else if (sel < 16) begin
        send(cfg.start_byte);
        repeat ($urandom_range(3)) send(8'($urandom));
      end else if (sel < 22 && cfg.length_limit != 16'hFFFF) begin
        len = ($urandom_range(3) == 0) ? 16'hFFFF
            : $urandom_range(16'hFFFF, int'(cfg.length_limit) + 1);
        push_frame(16'(len), $urandom_range(3), 8'($urandom));
      end else begin
        sel = $urandom_range(99);
        ftype = (sel < 45) ? cfg.msg_type : (sel < 65) ? cfg.wait_type : 8'($urandom);
        top = (cfg.length_limit < 14) ? cfg.length_limit : 14;
        len = $urandom_range(top);
        push_frame(16'(len), len, ftype);
      end
    end
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || rx_valid || result_q.size() != 0) @(posedge clk_i);
    // bytes that give no result may still be in the pipeline
    repeat (6) @(posedge clk_i);
  endtask

  // register write with setup and access phases, mirrored into the local copy
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {16'h0000, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_START_BYTE:   cfg.start_byte = val[7:0];
      REG_MSG_TYPE:     cfg.msg_type = val[7:0];
      REG_WAIT_TYPE:    cfg.wait_type = val[7:0];
      REG_LENGTH_LIMIT: cfg.length_limit = val;
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [7:0] sb, input logic [7:0] mt,
                              input logic [7:0] wt, input logic [15:0] lim);
    wait_drained();
    write_reg(REG_START_BYTE, {8'h00, sb});
    write_reg(REG_MSG_TYPE, {8'h00, mt});
    write_reg(REG_WAIT_TYPE, {8'h00, wt});
    write_reg(REG_LENGTH_LIMIT, lim);
    settings_run++;
  endtask

  initial begin
    cfg.start_byte = START_BYTE_RST;
    cfg.msg_type = MSG_TYPE_RST;
    cfg.wait_type = WAIT_TYPE_RST;
    cfg.length_limit = LENGTH_LIMIT_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames under reset register values
    send(8'h00);
    send(8'hFF);
    send(START_BYTE_RST);                 // message whose last text byte is NUL
    send(8'd7);
    send(8'd0);
    send(MSG_TYPE_RST);
    send(8'hFF);
    repeat (4) send(8'($urandom));
    send(8'h00);
    push_frame(16'd6, 6, MSG_TYPE_RST);   // message with no text
    push_frame(16'd1, 1, WAIT_TYPE_RST);  // one-byte fetch frame
    push_frame(16'd5, 5, MSG_TYPE_RST);   // too short for a message
    push_frame(16'd0, 0, 8'h00);          // empty frame
    push_frame(16'd512, 0, 8'h00);        // just over the limit
    push_frame(16'hFFFF, 0, 8'h00);
    gen_frames(300);

    // low extremes: every nonzero length is oversize
    load_setting(8'h00, 8'hFF, 8'h00, 16'h0000);
    gen_frames(150);

    // high extremes with equal type codes, one long message without gaps
    load_setting(8'hFF, 8'hA5, 8'hA5, 16'hFFFF);
    idle_pct = 0;
    push_frame(16'd300, 300, 8'hA5);
    wait_drained();
    idle_pct = 32;
    push_frame(16'd3, 3, 8'hA5);
    gen_frames(200);

    // random codes with a small limit, frames right at and just past it
    load_setting(8'($urandom), 8'($urandom), 8'($urandom), 16'd20);
    push_frame(16'd20, 20, cfg.msg_type);
    push_frame(16'd21, 0, 8'h00);
    gen_frames(200);

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d received bytes under %0d register settings", bytes_taken,
             settings_run);
    $display("checked %0d results field by field", results_seen);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for the receiver");
    $display("testbench: errors");
    $finish;
  end

endmodule
